@@ rtl/soc_pkg.sv @@
// ---------------------------------------------------------------------------
// Segment obstacle clearance package
// Shared types and constants for the clearance checker.
// ---------------------------------------------------------------------------
package soc_pkg;

    localparam int CFG_W = 15;
    localparam int COORD_W = 16;
    localparam int CLEAR_W = 18;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    localparam logic [1:0] REG_HORIZON = 2'd0;
    localparam logic [1:0] REG_LATERAL_LIMIT = 2'd1;
    localparam logic [1:0] REG_SAFETY_MARGIN = 2'd2;

    localparam logic [CFG_W-1:0] HORIZON_RESET = 15'd2560;
    localparam logic [CFG_W-1:0] LATERAL_LIMIT_RESET = 15'd768;
    localparam logic [CFG_W-1:0] SAFETY_MARGIN_RESET = 15'd77;

    typedef enum logic [1:0] {
        KIND_CLEAR,
        KIND_APPEND,
        KIND_QUERY,
        KIND_IGNORE
    } kind_t;

    typedef struct packed {
        kind_t kind;
        logic signed [COORD_W-1:0] obstacle_x;
        logic signed [COORD_W-1:0] obstacle_y;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } item_t;

    typedef struct packed {
        logic [CFG_W-1:0] horizon;
        logic [CFG_W-1:0] lateral_limit;
        logic [CFG_W-1:0] safety_margin;
    } cfg_t;

endpackage

@@ rtl/soc_if.sv @@
// ---------------------------------------------------------------------------
// Segment obstacle clearance channels
// Request, response and configuration channels with valid/ready.
// ---------------------------------------------------------------------------
interface soc_req_if;
    logic valid;
    logic ready;
    logic [1:0] operation;
    logic signed [15:0] obstacle_x;
    logic signed [15:0] obstacle_y;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    modport source (output valid, operation, obstacle_x, obstacle_y, start_x, start_y,
                    end_x, end_y, input ready);
    modport sink (input valid, operation, obstacle_x, obstacle_y, start_x, start_y,
                  end_x, end_y, output ready);
endinterface

interface soc_rsp_if;
    logic valid;
    logic ready;
    logic signed [17:0] clearance;
    logic is_free;
    logic status;
    modport source (output valid, clearance, is_free, status, input ready);
    modport sink (input valid, clearance, is_free, status, output ready);
endinterface

interface soc_cfg_if;
    logic valid;
    logic ready;
    logic [1:0] index;
    logic [14:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/soc_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module soc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic clk,
    input  logic we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/soc_front.sv @@
// ---------------------------------------------------------------------------
// Segment obstacle clearance front end
// Accepts request beats, classifies the operation and queues the item.
// ---------------------------------------------------------------------------
module soc_front import soc_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    soc_req_if.sink req,
    output item_t q_item,
    output logic q_valid,
    input  logic q_pop
);

    item_t slot_reg [2];
    logic wr_ptr_reg;
    logic rd_ptr_reg;
    logic [1:0] fill_reg;
    logic push;
    item_t item_in;

    assign req.ready = (fill_reg != 2'd2);
    assign push = req.valid && req.ready;
    assign q_valid = (fill_reg != 2'd0);
    assign q_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.obstacle_x = req.obstacle_x;
        item_in.obstacle_y = req.obstacle_y;
        item_in.start_x = req.start_x;
        item_in.start_y = req.start_y;
        item_in.end_x = req.end_x;
        item_in.end_y = req.end_y;
        case (req.operation)
            OP_CLEAR:  item_in.kind = KIND_CLEAR;
            OP_APPEND: item_in.kind = KIND_APPEND;
            OP_QUERY:  item_in.kind = KIND_QUERY;
            default:   item_in.kind = KIND_IGNORE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> fill_reg != 2'd0)
        else $error("Queue popped while empty.");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg != 2'd3)
        else $error("Queue fill level out of range.");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> fill_reg == $past(fill_reg) + 2'd1)
        else $error("Queue fill level did not advance on a push.");

endmodule

@@ rtl/soc_back.sv @@
// ---------------------------------------------------------------------------
// Segment obstacle clearance back end
// Executes queued items: table updates and sampled segment queries.
// ---------------------------------------------------------------------------
module soc_back import soc_pkg::*; #(
    parameter int MAX_OBSTACLES = 256,
    parameter int MAX_CHECKS = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  item_t q_item,
    input  logic q_valid,
    output logic q_pop,
    soc_rsp_if.source rsp
);

    localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    localparam int NW = $clog2(MAX_OBSTACLES + 1);
    localparam int CW = $clog2(MAX_CHECKS + 1);
    localparam int SQW = 2 * CFG_W + 2 * CW;
    localparam int LW = (SQW > 37) ? SQW : 37;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQUARE,
        S_LEN,
        S_COUNT,
        S_DIV_INIT,
        S_DIV,
        S_SAMPLE,
        S_SCAN,
        S_DRAIN,
        S_ROOT,
        S_NEXT
    } state_t;

    state_t state_reg;
    logic [NW-1:0] count_reg;
    logic signed [15:0] x1_reg;
    logic signed [15:0] y1_reg;
    logic signed [16:0] dx_reg;
    logic signed [16:0] dy_reg;
    logic [33:0] dx2_reg;
    logic [33:0] dy2_reg;
    logic [29:0] a2_reg;
    logic [LW-1:0] four_l2_reg;
    logic [SQW-1:0] sq_reg;
    logic [SQW-1:0] delta_reg;
    logic [CW-1:0] c_reg;
    logic [CW-1:0] checks_reg;
    logic [3:0] div_cnt_reg;
    logic [15:0] nx_reg;
    logic [15:0] ny_reg;
    logic [CW-1:0] remx_reg;
    logic [CW-1:0] remy_reg;
    logic [15:0] stepx_reg;
    logic [15:0] stepy_reg;
    logic [CW-1:0] fracx_reg;
    logic [CW-1:0] fracy_reg;
    logic [CW-1:0] i_reg;
    logic [15:0] qx_reg;
    logic [15:0] qy_reg;
    logic [CW-1:0] rx_reg;
    logic [CW-1:0] ry_reg;
    logic [NW-1:0] k_reg;
    logic v1_reg;
    logic v2_reg;
    logic first_reg;
    logic [33:0] sqx_reg;
    logic [33:0] sqy_reg;
    logic [33:0] best_d2_reg;
    logic [33:0] rv_reg;
    logic [33:0] rr_reg;
    logic [33:0] rbit_reg;
    logic signed [18:0] cand_reg;
    logic signed [18:0] best_reg;
    logic out_valid_reg;
    logic signed [17:0] out_clear_reg;
    logic out_free_reg;
    logic out_status_reg;

    logic ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [31:0] ram_rdata;

    logic signed [17:0] sx;
    logic signed [17:0] sy;
    logic [17:0] ay;
    logic outside;
    logic signed [17:0] dxo;
    logic signed [17:0] dyo;
    logic signed [35:0] px;
    logic signed [35:0] py;
    logic [33:0] d2;
    logic [CW:0] remx_sh;
    logic [CW:0] remy_sh;
    logic gex;
    logic gey;
    logic [CW:0] rx_sum;
    logic [CW:0] ry_sum;
    logic [33:0] root_try;
    logic signed [18:0] best_new;
    logic signed [18:0] infl_s;
    logic [15:0] abs_dx;
    logic [15:0] abs_dy;
    logic signed [16:0] dx_in;
    logic signed [16:0] dy_in;
    logic signed [33:0] dx_sq;
    logic signed [33:0] dy_sq;

    soc_ram #(.WIDTH(32), .DEPTH(MAX_OBSTACLES)) u_table (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign q_pop = (state_reg == S_IDLE) && q_valid && !out_valid_reg;
    assign ram_we = q_pop && (q_item.kind == KIND_APPEND) && (count_reg < NW'(MAX_OBSTACLES));
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = {q_item.obstacle_x, q_item.obstacle_y};
    assign ram_raddr = k_reg[AW-1:0];

    assign infl_s = $signed({4'b0, cfg.safety_margin});
    assign dx_in = 17'(q_item.end_x) - 17'(q_item.start_x);
    assign dy_in = 17'(q_item.end_y) - 17'(q_item.start_y);
    assign dx_sq = dx_reg * dx_reg;
    assign dy_sq = dy_reg * dy_reg;
    assign abs_dx = dx_reg[16] ? 16'(-dx_reg) : dx_reg[15:0];
    assign abs_dy = dy_reg[16] ? 16'(-dy_reg) : dy_reg[15:0];

    assign sx = 18'(x1_reg) + (dx_reg[16] ? -$signed({2'b0, qx_reg}) : $signed({2'b0, qx_reg}));
    assign sy = 18'(y1_reg) + (dy_reg[16] ? -$signed({2'b0, qy_reg}) : $signed({2'b0, qy_reg}));
    assign ay = sy[17] ? 18'(-sy) : sy;
    assign outside = sx[17] || (sx > $signed({3'b0, cfg.horizon}))
                     || (ay > {3'b0, cfg.lateral_limit});

    assign dxo = sx - 18'($signed(ram_rdata[31:16]));
    assign dyo = sy - 18'($signed(ram_rdata[15:0]));
    assign px = dxo * dxo;
    assign py = dyo * dyo;
    assign d2 = sqx_reg + sqy_reg;

    assign remx_sh = {remx_reg, nx_reg[15]};
    assign remy_sh = {remy_reg, ny_reg[15]};
    assign gex = remx_sh >= {1'b0, checks_reg};
    assign gey = remy_sh >= {1'b0, checks_reg};

    assign rx_sum = {1'b0, rx_reg} + {1'b0, fracx_reg};
    assign ry_sum = {1'b0, ry_reg} + {1'b0, fracy_reg};

    assign root_try = rr_reg + rbit_reg;
    assign best_new = ((i_reg == '0) || (cand_reg < best_reg)) ? cand_reg : best_reg;

    assign rsp.valid = out_valid_reg;
    assign rsp.clearance = out_clear_reg;
    assign rsp.is_free = out_free_reg;
    assign rsp.status = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            v1_reg <= (state_reg == S_SCAN);
            v2_reg <= v1_reg;
            if (v1_reg)
            begin
                sqx_reg <= px[33:0];
                sqy_reg <= py[33:0];
            end
            if (v2_reg)
            begin
                first_reg <= 1'b0;
                if (first_reg || (d2 < best_d2_reg))
                begin
                    best_d2_reg <= d2;
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        x1_reg <= q_item.start_x;
                        y1_reg <= q_item.start_y;
                        dx_reg <= dx_in;
                        dy_reg <= dy_in;
                        out_clear_reg <= '0;
                        out_free_reg <= 1'b0;
                        out_status_reg <= 1'b0;
                        case (q_item.kind)
                            KIND_CLEAR:
                            begin
                                count_reg <= '0;
                                out_valid_reg <= 1'b1;
                            end
                            KIND_APPEND:
                            begin
                                if (ram_we)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                                else
                                begin
                                    out_status_reg <= 1'b1;
                                end
                                out_valid_reg <= 1'b1;
                            end
                            KIND_QUERY:
                            begin
                                state_reg <= S_SQUARE;
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_SQUARE:
                begin
                    dx2_reg <= dx_sq;
                    dy2_reg <= dy_sq;
                    a2_reg <= cfg.safety_margin * cfg.safety_margin;
                    state_reg <= S_LEN;
                end
                S_LEN:
                begin
                    four_l2_reg <= LW'({dx2_reg} + {dy2_reg}) << 2;
                    c_reg <= CW'(1);
                    sq_reg <= SQW'(a2_reg);
                    delta_reg <= SQW'(a2_reg) + (SQW'(a2_reg) << 1);
                    if (cfg.safety_margin == '0)
                    begin
                        checks_reg <= CW'(MAX_CHECKS);
                        state_reg <= S_DIV_INIT;
                    end
                    else
                    begin
                        state_reg <= S_COUNT;
                    end
                end
                S_COUNT:
                begin
                    if (LW'(sq_reg) >= four_l2_reg)
                    begin
                        checks_reg <= c_reg;
                        state_reg <= S_DIV_INIT;
                    end
                    else if (c_reg == CW'(MAX_CHECKS))
                    begin
                        checks_reg <= CW'(MAX_CHECKS);
                        state_reg <= S_DIV_INIT;
                    end
                    else
                    begin
                        c_reg <= c_reg + 1'b1;
                        sq_reg <= sq_reg + delta_reg;
                        delta_reg <= delta_reg + (SQW'(a2_reg) << 1);
                    end
                end
                S_DIV_INIT:
                begin
                    nx_reg <= abs_dx;
                    ny_reg <= abs_dy;
                    remx_reg <= '0;
                    remy_reg <= '0;
                    div_cnt_reg <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    nx_reg <= {nx_reg[14:0], gex};
                    ny_reg <= {ny_reg[14:0], gey};
                    remx_reg <= gex ? CW'(remx_sh - {1'b0, checks_reg}) : CW'(remx_sh);
                    remy_reg <= gey ? CW'(remy_sh - {1'b0, checks_reg}) : CW'(remy_sh);
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == 4'd15)
                    begin
                        stepx_reg <= {nx_reg[14:0], gex};
                        stepy_reg <= {ny_reg[14:0], gey};
                        fracx_reg <= gex ? CW'(remx_sh - {1'b0, checks_reg}) : CW'(remx_sh);
                        fracy_reg <= gey ? CW'(remy_sh - {1'b0, checks_reg}) : CW'(remy_sh);
                        i_reg <= '0;
                        qx_reg <= '0;
                        qy_reg <= '0;
                        rx_reg <= '0;
                        ry_reg <= '0;
                        state_reg <= S_SAMPLE;
                    end
                end
                S_SAMPLE:
                begin
                    k_reg <= '0;
                    first_reg <= 1'b1;
                    if (outside)
                    begin
                        cand_reg <= -infl_s;
                        state_reg <= S_NEXT;
                    end
                    else if (count_reg == '0)
                    begin
                        cand_reg <= $signed({4'b0, cfg.horizon});
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == count_reg - 1'b1)
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    if (!v1_reg && !v2_reg)
                    begin
                        rv_reg <= best_d2_reg;
                        rr_reg <= '0;
                        rbit_reg <= 34'd1 << 32;
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    if (rbit_reg == '0)
                    begin
                        cand_reg <= $signed({1'b0, rr_reg[17:0]}) - infl_s;
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        if (rv_reg >= root_try)
                        begin
                            rv_reg <= rv_reg - root_try;
                            rr_reg <= (rr_reg >> 1) + rbit_reg;
                        end
                        else
                        begin
                            rr_reg <= rr_reg >> 1;
                        end
                        rbit_reg <= rbit_reg >> 2;
                    end
                end
                S_NEXT:
                begin
                    best_reg <= best_new;
                    if (i_reg == checks_reg)
                    begin
                        out_clear_reg <= best_new[17:0];
                        out_free_reg <= !best_new[18];
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                        if (rx_sum >= {1'b0, checks_reg})
                        begin
                            rx_reg <= CW'(rx_sum - {1'b0, checks_reg});
                            qx_reg <= qx_reg + stepx_reg + 16'd1;
                        end
                        else
                        begin
                            rx_reg <= CW'(rx_sum);
                            qx_reg <= qx_reg + stepx_reg;
                        end
                        if (ry_sum >= {1'b0, checks_reg})
                        begin
                            ry_reg <= CW'(ry_sum - {1'b0, checks_reg});
                            qy_reg <= qy_reg + stepy_reg + 16'd1;
                        end
                        else
                        begin
                            ry_reg <= CW'(ry_sum);
                            qy_reg <= qy_reg + stepy_reg;
                        end
                        state_reg <= S_SAMPLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(MAX_OBSTACLES))
        else $error("Obstacle count exceeds the table size.");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> k_reg < count_reg)
        else $error("Scan address beyond the filled table.");

    a_free_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_free_reg) |-> !out_clear_reg[17])
        else $error("Free flag set with a negative clearance.");

    a_checks_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> checks_reg != '0)
        else $error("Division by a zero sample count.");

endmodule

@@ rtl/segment_obstacle_clearance.sv @@
// ---------------------------------------------------------------------------
// Segment obstacle clearance checker
// Obstacle table with sampled segment clearance queries.
// ---------------------------------------------------------------------------
// Clear, append and unused operations execute in the idle state, then wait
// for their response beat to be taken. A query first squares the segment
// length, counts the checks (skipped when the safety margin is zero) and
// divides the segment into steps. Each of the checks+1 samples is then
// folded directly when it lies outside the window or the table is empty;
// otherwise one obstacle per cycle is read from the table memory port, the
// read pipeline drains, a square root follows and the minimum is folded.
// Items queue in a two-entry buffer in front of the execution unit.
module segment_obstacle_clearance import soc_pkg::*; #(
    parameter int MAX_OBSTACLES = 256,
    parameter int MAX_CHECKS = 64
) (
    input  logic clk,
    input  logic rst_n,
    soc_cfg_if.sink cfg,
    soc_req_if.sink req,
    soc_rsp_if.source rsp
);

    cfg_t cfg_reg;
    item_t q_item;
    logic q_valid;
    logic q_pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.horizon <= HORIZON_RESET;
            cfg_reg.lateral_limit <= LATERAL_LIMIT_RESET;
            cfg_reg.safety_margin <= SAFETY_MARGIN_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_HORIZON:       cfg_reg.horizon <= cfg.data;
                REG_LATERAL_LIMIT: cfg_reg.lateral_limit <= cfg.data;
                REG_SAFETY_MARGIN: cfg_reg.safety_margin <= cfg.data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    soc_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .q_item(q_item),
        .q_valid(q_valid),
        .q_pop(q_pop)
    );

    soc_back #(.MAX_OBSTACLES(MAX_OBSTACLES), .MAX_CHECKS(MAX_CHECKS)) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .q_item(q_item),
        .q_valid(q_valid),
        .q_pop(q_pop),
        .rsp(rsp)
    );

endmodule
